FILE: hw/rtl/sle_pkg.sv
// Shared types and constants for the sorted list engine.
package sle_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_LOCATE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CMP,
    ST_DEL_FETCH,
    ST_DEL_STEP,
    ST_DEL_MOVE,
    ST_RD_WAIT,
    ST_LOC_CMP,
    ST_RESP
  } state_e;

  // Memory read address relative to the working index
  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rd_off_e;

  // Memory write data source
  typedef enum logic {
    WR_MEM,
    WR_VAL
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_off_e rd_off;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_inc;
    logic    idx_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_ok;
    logic    set_res;
    logic    set_found;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic pos_ok;
    logic idx_zero;
    logic idx_end;
    logic idx_last;
    logic cmp_ge;
    logic match;
  } status_t;

endpackage

FILE: hw/rtl/sle_ctrl.sv
// Controller state machine: sequences the scan and shift passes over the list memory.
module sle_ctrl import sle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      // Dispatch on the opcode; loop head for insert (walking down) and locate (walking up)
      ST_DISPATCH: begin
        unique case (status_i.op)
          OP_INSERT: begin
            if (status_i.full) begin
              state_d = ST_RESP;
            end else if (status_i.idx_zero) begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_VAL;
              cmd_o.cnt_inc = 1'b1;
              cmd_o.set_ok  = 1'b1;
              state_d       = ST_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_off = RD_PREV;
              state_d      = ST_INS_CMP;
            end
          end
          OP_DELETE: begin
            if (!status_i.pos_ok) begin
              state_d = ST_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_off = RD_CUR;
              state_d      = ST_DEL_FETCH;
            end
          end
          OP_READ: begin
            if (!status_i.pos_ok) begin
              state_d = ST_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_off = RD_CUR;
              state_d      = ST_RD_WAIT;
            end
          end
          OP_LOCATE: begin
            if (status_i.idx_end) begin
              state_d = ST_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_off = RD_CUR;
              state_d      = ST_LOC_CMP;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.cmp_ge) begin
          // entry moves up one slot, keep walking down
          cmd_o.wr_sel  = WR_MEM;
          cmd_o.idx_dec = 1'b1;
          state_d       = ST_DISPATCH;
        end else begin
          cmd_o.wr_sel  = WR_VAL;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.set_ok  = 1'b1;
          state_d       = ST_RESP;
        end
      end
      ST_DEL_FETCH: begin
        cmd_o.set_res = 1'b1;
        cmd_o.set_ok  = 1'b1;
        state_d       = ST_DEL_STEP;
      end
      ST_DEL_STEP: begin
        if (status_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = ST_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_off = RD_NEXT;
          state_d      = ST_DEL_MOVE;
        end
      end
      ST_DEL_MOVE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_MEM;
        cmd_o.idx_inc = 1'b1;
        state_d       = ST_DEL_STEP;
      end
      ST_RD_WAIT: begin
        cmd_o.set_res = 1'b1;
        cmd_o.set_ok  = 1'b1;
        state_d       = ST_RESP;
      end
      ST_LOC_CMP: begin
        if (status_i.match) begin
          cmd_o.set_found = 1'b1;
          cmd_o.set_ok    = 1'b1;
          state_d         = ST_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/sle_dpath.sv
// Datapath: list memory, working index, entry count and result registers.
module sle_dpath import sle_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   in_opcode_i,
  input  logic [DATA_W-1:0] in_value_i,
  input  logic [POS_W-1:0]  in_position_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              ok_o,
  output logic [DATA_W-1:0] result_value_o,
  output logic [POS_W-1:0]  found_position_o,
  output logic [POS_W-1:0]  list_length_o,
  output logic              is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  op_e               op_q;
  logic [DATA_W-1:0] val_q;
  logic [POS_W-1:0]  pos_q;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ok_q;
  logic [DATA_W-1:0] res_q;
  logic [POS_W-1:0]  found_q;

  logic [LW-1:0]     cnt_ext, pos_ext, idx_p1, in_pos_ext;
  logic [CW-1:0]     ra;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;

  assign cnt_ext    = LW'(cnt_q);
  assign pos_ext    = LW'(pos_q);
  assign in_pos_ext = LW'(in_position_i);
  assign idx_p1     = LW'(idx_q) + LW'(1);

  always_comb begin
    unique case (cmd_i.rd_off)
      RD_PREV: ra = idx_q - CW'(1);
      RD_NEXT: ra = idx_q + CW'(1);
      default: ra = idx_q;
    endcase
  end

  assign raddr = ra[AW-1:0];
  assign waddr = idx_q[AW-1:0];
  assign wdata = (cmd_i.wr_sel == WR_VAL) ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Working index: starts at the top for insert, at position-1 for delete/read, at zero for locate
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      unique case (op_e'(in_opcode_i))
        OP_INSERT:          idx_d = cnt_q;
        OP_DELETE, OP_READ: idx_d = CW'(in_pos_ext - LW'(1));
        default:            idx_d = '0;
      endcase
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      op_q    <= op_e'(in_opcode_i);
      val_q   <= in_value_i;
      pos_q   <= in_position_i;
      ok_q    <= 1'b0;
      res_q   <= '0;
      found_q <= '0;
    end else begin
      if (cmd_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.set_res) begin
        res_q <= rdata_q;
      end
      if (cmd_i.set_found) begin
        found_q <= idx_p1[POS_W-1:0];
      end
    end
  end

  assign status_o.op       = op_q;
  assign status_o.full     = (cnt_ext == LW'(DEPTH));
  assign status_o.pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.idx_end  = (idx_q == cnt_q);
  assign status_o.idx_last = (idx_p1 == cnt_ext);
  assign status_o.cmp_ge   = ($signed(rdata_q) >= $signed(val_q));
  assign status_o.match    = (rdata_q == val_q);

  assign ok_o             = ok_q;
  assign result_value_o   = res_q;
  assign found_position_o = found_q;
  assign list_length_o    = cnt_ext[POS_W-1:0];
  assign is_empty_o       = (cnt_q == '0);

endmodule

FILE: hw/rtl/sorted_list_engine.sv
// Sorted list engine: ascending list of signed 32-bit values held in one memory.
//
// Usage: each input beat on s_axis carries an opcode in tuser (insert, delete at
// position, read at position, locate value) and value/position in tdata. Every
// beat yields exactly one result beat on m_axis with ok, the value read or
// removed, the locate position, the list length and an empty flag.
// One item is handled at a time; s_axis_tready is high only while the engine
// is idle, from the cycle after a result beat is taken. An insert moves each
// entry not below the new value up one slot, walking down from the top; a
// delete moves each entry above the position down one slot; a locate compares
// entries from the bottom up until a match or the end of the list. A full-list
// insert or an out-of-range read or delete moves nothing. The list memory has a
// registered read, so each moved or compared entry takes a read and then a
// write or compare. Reset empties the list at once; memory contents are not
// cleared since only entries below the count are ever read. A stalled result
// is held in the output register until m_axis_tready; no new beat is taken
// meanwhile.
module sorted_list_engine import sle_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value[31:0], position[42:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // ok[0], result_value[32:1], found_position[43:33],
                                      // list_length[54:44], is_empty[55]
);

  cmd_t              cmd;
  status_t           status;
  logic              ok;
  logic [DATA_W-1:0] result_value;
  logic [POS_W-1:0]  found_position;
  logic [POS_W-1:0]  list_length;
  logic              is_empty;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sle_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_opcode_i      (s_axis_tuser),
    .in_value_i       (s_axis_tdata[DATA_W-1:0]),
    .in_position_i    (s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
    .cmd_i            (cmd),
    .status_o         (status),
    .ok_o             (ok),
    .result_value_o   (result_value),
    .found_position_o (found_position),
    .list_length_o    (list_length),
    .is_empty_o       (is_empty)
  );

  assign m_axis_tdata = {is_empty, list_length, found_position, result_value, ok};

  // Engine never takes a new beat while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // An accepted beat never produces a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result valid one cycle after accept");

  // After a result beat is taken the engine is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not idle after result beat");

  // Empty flag agrees with the reported length when the length is not masked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((DEPTH > 2047) || (is_empty == (list_length == '0))))
    else $error("empty flag disagrees with list length");

endmodule

FILE: test/tb_sorted_list_engine.sv
// Self-checking testbench for sorted_list_engine: predicts each result beat and checks it field by field.
`timescale 1ns / 1ps

module tb_sorted_list_engine import sle_pkg::*; ();

  localparam int unsigned LIST_DEPTH   = 1024;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned FILL_LEN     = 160;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned SETTLE_CYCLES = 2 * LIST_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  localparam logic [31:0] MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [10:0] POS_ALL_ONES = 11'h7FF;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PERIODIC
  } rx_pattern_e;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
    logic [10:0] found;
    logic [10:0] length;
    logic        empty;
  } list_response_t;

  class list_scoreboard;
    logic [31:0]    shadow_list[$];  // ascending by signed value
    list_response_t expected_q[$];
    int unsigned    depth_limit;
    int unsigned    failures;
    int unsigned    beat_index;

    function new(int unsigned depth);
      depth_limit = depth;
      failures = 0;
      beat_index = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_command(op_e op, logic [31:0] value, logic [10:0] pos);
      list_response_t resp;
      int unsigned slot;
      resp = '0;
      case (op)
        OP_INSERT: begin
          if (shadow_list.size() < depth_limit) begin
            slot = 0;
            while (slot < shadow_list.size() && $signed(shadow_list[slot]) < $signed(value))
              slot++;
            shadow_list.insert(slot, value);
            resp.ok = 1'b1;
          end
        end
        OP_DELETE, OP_READ: begin
          if (pos >= 1 && pos <= shadow_list.size()) begin
            resp.ok = 1'b1;
            resp.value = shadow_list[pos - 1];
            if (op == OP_DELETE) shadow_list.delete(pos - 1);
          end
        end
        OP_LOCATE: begin
          for (slot = 0; slot < shadow_list.size(); slot++) begin
            if (shadow_list[slot] == value) begin
              resp.ok = 1'b1;
              resp.found = 11'(slot + 1);
              break;
            end
          end
        end
        default: ;
      endcase
      resp.length = 11'(shadow_list.size());
      resp.empty = (shadow_list.size() == 0);
      expected_q.push_back(resp);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      failures++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s got 0x%0h, expected 0x%0h", beat_index, field, got, want));
    endtask

    task check_response(logic [55:0] beat);
      list_response_t want;
      beat_index++;
      if (expected_q.size() == 0) begin
        report($sformatf("beat %0d arrived with no command outstanding", beat_index));
        return;
      end
      want = expected_q.pop_front();
      compare("ok", 32'(beat[0]), 32'(want.ok));
      compare("result_value", beat[32:1], want.value);
      compare("found_position", 32'(beat[43:33]), 32'(want.found));
      compare("list_length", 32'(beat[54:44]), 32'(want.length));
      compare("is_empty", 32'(beat[55]), 32'(want.empty));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // value[31:0], position[42:32], zero pad
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // ok, result_value, found_position, list_length, is_empty

  list_scoreboard sb = new(LIST_DEPTH);

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          steady_sender = 1'b0;
  logic        rx_holding = 1'b0;
  rx_pattern_e rx_pattern = RX_ALWAYS;
  int unsigned rx_pattern_left = 0;
  logic        rx_ready_next;
  event        hold_off_ev;

  sorted_list_engine #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: check each accepted beat, then pick the next ready from the current pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
    if (rx_pattern_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_pattern_left = $urandom_range(20, 200);
    end else begin
      rx_pattern_left--;
    end
    case (rx_pattern)
      RX_ALWAYS:   rx_ready_next = 1'b1;
      RX_COIN:     rx_ready_next = 1'($urandom_range(0, 1));
      RX_MOSTLY:   rx_ready_next = ($urandom_range(0, 3) != 0);
      default:     rx_ready_next = ((cycle_count % 7) >= 3);
    endcase
    m_axis_tready <= rx_ready_next && !rx_holding;
  end

  // Long receiver hold-off so the engine backs up into its input
  always begin
    @(hold_off_ev);
    rx_holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_holding <= 1'b0;
  end

  task automatic send_command(input op_e op, input logic [31:0] value, input logic [10:0] pos);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, pos, value};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, value, pos);
    if (!steady_sender) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Delete from the tail: cheapest way to empty the list
  task automatic drain_list();
    while (sb.shadow_list.size() > 0)
      send_command(OP_DELETE, $urandom(), 11'(sb.shadow_list.size()));
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 9);
    len = sb.shadow_list.size();
    if (r < 4) return $urandom_range(0, 16) - 32'd8;
    if (r < 6 && len > 0) return sb.shadow_list[$urandom_range(0, len - 1)];
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0:       return MIN_VAL;
        1:       return MAX_VAL;
        2:       return ALL_ONES;
        default: return 32'd0;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [10:0] pick_position();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 9);
    len = sb.shadow_list.size();
    if (r < 7) return (len == 0) ? 11'd1 : 11'($urandom_range(1, len));
    if (r == 7) return 11'd0;
    if (r == 8) return 11'(len + 1);
    return 11'($urandom_range(0, 2047));
  endfunction

  initial begin
    logic [31:0] fill_value;
    logic [31:0] mid_value;
    int unsigned n;
    int unsigned sel;
    int unsigned ins_weight;
    int unsigned len;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: out-of-range positions and a miss
    send_command(OP_READ, 32'd0, 11'd1);
    send_command(OP_DELETE, 32'd0, 11'd1);
    send_command(OP_LOCATE, 32'd0, 11'd0);
    send_command(OP_DELETE, 32'd0, 11'd0);
    // extremes and duplicates
    send_command(OP_INSERT, 32'd0, 11'd0);
    send_command(OP_INSERT, MAX_VAL, 11'd0);
    send_command(OP_INSERT, MIN_VAL, POS_ALL_ONES);
    send_command(OP_INSERT, ALL_ONES, 11'd0);
    send_command(OP_INSERT, 32'd0, 11'd0);
    send_command(OP_INSERT, MAX_VAL, 11'd0);
    send_command(OP_LOCATE, 32'd0, 11'd0);
    send_command(OP_LOCATE, MAX_VAL, 11'd0);
    send_command(OP_LOCATE, 32'd12345, 11'd0);
    send_command(OP_LOCATE, MIN_VAL, POS_ALL_ONES);
    send_command(OP_READ, 32'd0, 11'd1);
    send_command(OP_READ, 32'd0, 11'd6);
    send_command(OP_READ, 32'd0, 11'd7);
    send_command(OP_READ, ALL_ONES, 11'd0);
    send_command(OP_READ, 32'd0, POS_ALL_ONES);
    send_command(OP_READ, 32'd0, 11'(LIST_DEPTH));
    send_command(OP_DELETE, 32'd0, 11'd3);
    send_command(OP_DELETE, 32'd0, 11'd5);
    send_command(OP_DELETE, 32'd0, 11'd1);
    send_command(OP_DELETE, 32'd0, 11'd0);
    send_command(OP_DELETE, 32'd0, POS_ALL_ONES);
    drain_list();

    // grow a long list in ascending order (tail inserts are short)
    fill_value = MIN_VAL;
    while (sb.shadow_list.size() < FILL_LEN) begin
      if (sb.shadow_list.size() == 100) begin
        steady_sender = 1'b1;
        -> hold_off_ev;
      end
      if (sb.shadow_list.size() == 140) steady_sender = 1'b0;
      send_command(OP_INSERT, fill_value, 11'($urandom_range(0, 2047)));
      fill_value += $urandom_range(0, 2_000_000);
    end

    // long list: shifts and scans across every entry
    send_command(OP_INSERT, MIN_VAL, 11'd0);
    send_command(OP_READ, 32'd0, 11'(FILL_LEN + 1));
    send_command(OP_READ, 32'd0, 11'(FILL_LEN + 2));
    send_command(OP_LOCATE, sb.shadow_list[FILL_LEN], 11'd0);
    send_command(OP_LOCATE, MAX_VAL, 11'd0);
    send_command(OP_DELETE, 32'd0, 11'(FILL_LEN + 1));
    mid_value = sb.shadow_list[FILL_LEN / 2];
    send_command(OP_INSERT, mid_value, 11'd0);
    send_command(OP_DELETE, 32'd0, 11'd1);
    send_command(OP_INSERT, MAX_VAL, 11'd0);
    send_command(OP_LOCATE, MAX_VAL, 11'd0);
    drain_list();

    // random mix, list length kept short so most items stay fast
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      len = sb.shadow_list.size();
      ins_weight = (len < 8) ? 55 : ((len > 40) ? 15 : 35);
      sel = $urandom_range(0, 99);
      if (sel < ins_weight)
        send_command(OP_INSERT, pick_value(), 11'($urandom_range(0, 2047)));
      else if (sel < ins_weight + 25)
        send_command(OP_DELETE, $urandom(), pick_position());
      else if (sel < ins_weight + 45)
        send_command(OP_READ, $urandom(), pick_position());
      else
        send_command(OP_LOCATE, pick_value(), 11'($urandom_range(0, 2047)));
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_ctrl.sv
hw/rtl/sle_dpath.sv
hw/rtl/sorted_list_engine.sv
test/tb_sorted_list_engine.sv
